// ===== rtl/core/slip_deframer_sum_check_top_defines.svh =====
// ----------------------------------------------------------------------------
// slip deframer assertion macros
// shared concurrent assertion forms, clocked on clock, disabled in reset
// ----------------------------------------------------------------------------
`ifndef SLIP_DEFRAMER_SUM_CHECK_TOP_DEFINES_SVH
`define SLIP_DEFRAMER_SUM_CHECK_TOP_DEFINES_SVH

// same-cycle implication
`define SDSC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SDSC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/sdsc_pkg.sv =====
// ----------------------------------------------------------------------------
// sdsc_pkg
// shared types and constants of the slip deframer with additive checksum
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sdsc_pkg;

   localparam int MAX_FRAME   = 512;
   localparam int FRAME_CNT_W = $clog2(MAX_FRAME + 1);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CODE_END     = 8'hc0;
   localparam logic [7:0] CODE_ESC     = 8'hdb;
   localparam logic [7:0] CODE_ESC_END = 8'hdc;
   localparam logic [7:0] CODE_ESC_ESC = 8'hdd;
   localparam logic [7:0] SUM_GOOD     = 8'hff;

   localparam logic [1:0] KIND_DATA     = 2'd0;
   localparam logic [1:0] KIND_GOOD     = 2'd1;
   localparam logic [1:0] KIND_BAD      = 2'd2;
   localparam logic [1:0] KIND_OVERFLOW = 2'd3;

   // one classified line byte: a frame end or a decoded data byte
   typedef struct packed {
      logic       is_end;
      logic [7:0] data;
   } sdsc_op_type;

endpackage

// ===== rtl/core/sdsc_front.sv =====
// ----------------------------------------------------------------------------
// sdsc_front
// accepts line bytes, tracks the escape flag and classifies each request
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdsc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  logic [7:0]           req_rx_byte,
   input  logic                 queue_full,
   output logic                 op_push,
   output sdsc_pkg::sdsc_op_type op
);
   import sdsc_pkg::*;

   logic escape_ff;
   logic escape_in;
   logic accept;
   logic is_esc;

   assign accept = req_push && !queue_full;
   assign is_esc = (req_rx_byte == CODE_ESC);

   always_comb begin
      escape_in = escape_ff;
      if (accept) begin
         escape_in = is_esc;
      end
   end

   always_comb begin
      op.is_end = (req_rx_byte == CODE_END);
      priority if (escape_ff && req_rx_byte == CODE_ESC_END) begin
         op.data = CODE_END;
      end else if (escape_ff && req_rx_byte == CODE_ESC_ESC) begin
         op.data = CODE_ESC;
      end else begin
         op.data = req_rx_byte;
      end
   end

   assign op_push = accept && !is_esc;

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_ff <= 1'b0;
      end else begin
         escape_ff <= escape_in;
      end
   end

endmodule

// ===== rtl/core/sdsc_queue.sv =====
// ----------------------------------------------------------------------------
// sdsc_queue
// short register queue between the classifier and the frame checker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdsc_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  sdsc_pkg::sdsc_op_type push_op,
   output logic                  full,
   output logic                  valid,
   output sdsc_pkg::sdsc_op_type head_op,
   input  logic                  pop
);
   import sdsc_pkg::*;

   sdsc_op_type       slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;
   logic              do_push;
   logic              do_pop;

   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign valid   = (count_ff != '0);
   assign head_op = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/core/sdsc_back.sv =====
// ----------------------------------------------------------------------------
// sdsc_back
// keeps the running sum and byte count and builds each result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "slip_deframer_sum_check_top_defines.svh"

module sdsc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  op_valid,
   input  sdsc_pkg::sdsc_op_type op,
   output logic                  op_pop,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [1:0]            rsp_kind,
   output logic [7:0]            rsp_data_byte,
   output logic [8:0]            rsp_byte_index,
   output logic [9:0]            rsp_frame_length
);
   import sdsc_pkg::*;

   logic [7:0]             sum_ff;
   logic [7:0]             sum_in;
   logic [FRAME_CNT_W-1:0] count_ff;
   logic [FRAME_CNT_W-1:0] count_in;
   logic                   out_valid_ff;
   logic                   out_valid_in;
   logic [1:0]             kind_ff;
   logic [1:0]             kind_in;
   logic [7:0]             data_ff;
   logic [7:0]             data_in;
   logic [8:0]             index_ff;
   logic [8:0]             index_in;
   logic [9:0]             length_ff;
   logic [9:0]             length_in;
   logic                   take;
   logic                   count_zero;
   logic                   count_max;

   assign take       = op_valid && (!out_valid_ff || rsp_pop);
   assign op_pop     = take;
   assign count_zero = (count_ff == '0);
   assign count_max  = (count_ff == FRAME_CNT_W'(MAX_FRAME));

   always_comb begin
      sum_in       = sum_ff;
      count_in     = count_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      kind_in      = kind_ff;
      data_in      = data_ff;
      index_in     = index_ff;
      length_in    = length_ff;
      if (take) begin
         priority if (op.is_end) begin
            // empty frame gives no result
            out_valid_in = !count_zero;
            kind_in      = (sum_ff == SUM_GOOD) ? KIND_GOOD : KIND_BAD;
            data_in      = '0;
            index_in     = '0;
            length_in    = 10'(count_ff);
            sum_in       = '0;
            count_in     = '0;
         end else if (count_max) begin
            out_valid_in = 1'b1;
            kind_in      = KIND_OVERFLOW;
            data_in      = '0;
            index_in     = '0;
            length_in    = 10'(count_ff);
            sum_in       = '0;
            count_in     = '0;
         end else begin
            out_valid_in = 1'b1;
            kind_in      = KIND_DATA;
            data_in      = op.data;
            index_in     = 9'(count_ff);
            length_in    = '0;
            sum_in       = sum_ff + op.data;
            count_in     = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      data_ff   <= data_in;
      index_ff  <= index_in;
      length_ff <= length_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_data_byte    = data_ff;
   assign rsp_byte_index   = index_ff;
   assign rsp_frame_length = length_ff;

   `SDSC_ASSERT_NOW(a_count_range, 1'b1, count_ff <= FRAME_CNT_W'(MAX_FRAME), "count overrun")
   `SDSC_ASSERT_NEXT(a_end_clears, take && op.is_end, count_ff == '0 && sum_ff == '0, "frame end did not clear")
   `SDSC_ASSERT_NOW(a_data_fields, out_valid_ff && kind_ff != KIND_DATA, data_ff == '0 && index_ff == '0, "end result carries data")

endmodule

// ===== rtl/core/slip_deframer_sum_check_top.sv =====
// ----------------------------------------------------------------------------
// slip_deframer_sum_check_top: slip deframer with additive frame checksum
// path: an accepted request is classified, held in sdsc_queue, then registered as a result in sdsc_back
// throughput: one request per cycle while req_full is low; the queue fills when rsp_pop does not drain results
// reset: synchronous; clears escape flag, sum, count, queue and result valid flag
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slip_deframer_sum_check_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_data_byte,
   output logic [8:0] rsp_byte_index,
   output logic [9:0] rsp_frame_length
);
   import sdsc_pkg::*;

   sdsc_op_type front_op;
   sdsc_op_type head_op;
   logic        front_push;
   logic        queue_full;
   logic        queue_valid;
   logic        queue_pop;

   assign req_full = queue_full;

   sdsc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_rx_byte (req_rx_byte),
      .queue_full  (queue_full),
      .op_push     (front_push),
      .op          (front_op)
   );

   sdsc_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (front_push),
      .push_op (front_op),
      .full    (queue_full),
      .valid   (queue_valid),
      .head_op (head_op),
      .pop     (queue_pop)
   );

   sdsc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .op_valid         (queue_valid),
      .op               (head_op),
      .op_pop           (queue_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_kind         (rsp_kind),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_frame_length (rsp_frame_length)
   );

endmodule
